FILE: rtl/mpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_pkg: shared types and constants for the max pool argmax unit
// word layouts, register indexes, sequencer states
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_CHANNELS = 64;
  localparam int MAX_POOL     = 8;
  localparam int MAX_HEIGHT   = 4096;
  localparam int SAMPLE_BITS  = 16;

  localparam int ROW_BITS  = 12;
  localparam int COL_BITS  = 8;
  localparam int CHAN_BITS = 6;
  localparam int SLOT_BITS = 3;
  localparam int ADDR_BITS = SLOT_BITS + COL_BITS + CHAN_BITS;
  localparam int ENTRY_BITS = SAMPLE_BITS + 8;
  localparam int CFG_BITS  = 9;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_ROWS   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_COLS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STEP      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_STEP      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP_PAD       = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_PAD      = 3'd7;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pooled_max;
    logic [2:0]         win_row_offset;
    logic [2:0]         win_col_offset;
    logic [11:0]        out_row;
    logic [7:0]         out_col;
    logic [5:0]         out_channel;
    logic               frame_done;
  } out_word_t;

  // clamped configuration
  typedef struct packed {
    logic [9:0] width;   // 1..256
    logic [6:0] chans;   // 1..64
    logic [3:0] wr;      // 1..8
    logic [3:0] wc;
    logic [3:0] rs;      // 1..15
    logic [3:0] cs;
    logic [2:0] tp;
    logic [2:0] lp;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_READ,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/max_pool_2d_argmax_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_argmax_unit: streaming 2-d max pooling with argmax
// one sample word in, at most one window result word out
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_data) carries samples in row, column,
//   channel order; frame_last marks the last sample of the map
//   out channel (out_valid/out_ready/out_data) carries one word per closed
//   window: maximum, winner offsets, output coordinates, frame_done
//   configuration is written through cfg_write/cfg_index/cfg_data while idle
// timing
//   each sample walks the window cells (i, j) through one shared divider:
//   a row-step division per row candidate plus a step to close the row,
//   a column-step division per column candidate plus a read and an update
//   step when that column hits a window
//   in_ready is high only in idle
//   a result word comes out before in_ready returns
// reset
//   counters, state and flags return to defaults; the partial window store is
//   not cleared, a window entry is always written by its first sample
// stall
//   a result waits in the output register; the sequencer holds in its last
//   state with in_ready low until the word is taken
// ----------------------------------------------------------------------------
module max_pool_2d_argmax_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mpa_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mpa_pkg::out_word_t            out_data,
  input  logic                          cfg_write,
  input  logic [mpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mpa_pkg::CFG_BITS-1:0]  cfg_data
);
  import mpa_pkg::*;

  cfg_t cfg;

  mpa_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  // sequencer state
  state_t state, state_next;

  logic [ROW_BITS-1:0]  row_counter;
  logic [COL_BITS-1:0]  col_counter;
  logic [CHAN_BITS-1:0] chan_counter;

  // latched current sample and position
  logic signed [15:0]   cur_sample;
  logic                 cur_last;
  logic [ROW_BITS-1:0]  r;
  logic [8:0]           x;
  logic [CHAN_BITS-1:0] c;
  logic                 emitted;

  // loop indexes
  logic [3:0]  i, j;
  logic [15:0] oh;
  logic [15:0] ow;
  logic [3:0]  i0;
  logic        row_ok;

  // shared divider
  logic        div_start, div_done;
  logic [15:0] div_dividend, div_q;
  logic [3:0]  div_divisor, div_rem;
  logic        div_busy;

  mpa_divstep u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  // window store
  logic [ENTRY_BITS-1:0] store [0:(1<<ADDR_BITS)-1];
  logic [ENTRY_BITS-1:0] rd_entry;
  logic [ADDR_BITS-1:0]  addr;
  logic                  wr_en;
  logic [ENTRY_BITS-1:0] wr_entry;

  // row / column candidate terms
  logic signed [16:0] t_val, u_val;
  assign t_val = $signed({5'd0, r}) + $signed({14'd0, cfg.tp}) - $signed({13'd0, i});
  assign u_val = $signed({8'd0, x}) + $signed({14'd0, cfg.lp}) - $signed({13'd0, j});

  // column window checks (registered quotient, narrow products)
  logic [19:0] ow_cs;
  logic [19:0] oh_rs;
  logic [3:0]  j0;
  logic        col_live;
  assign ow_cs = 20'(ow) * 20'(cfg.cs);
  assign oh_rs = 20'(oh) * 20'(cfg.rs);
  assign j0 = ({17'd0, cfg.lp} > ow_cs) ? 4'(20'(cfg.lp) - ow_cs) : 4'd0;
  assign col_live = (ow < 16'(MAX_WIDTH)) &&
                    ((ow_cs + 20'(cfg.wc) - 20'd1) < (20'(cfg.width) + 20'(cfg.lp)));
  assign addr = {oh[SLOT_BITS-1:0], ow[COL_BITS-1:0], c};

  logic first_cell, better, is_last_cell;
  logic signed [15:0] stored_max;
  assign stored_max = rd_entry[15:0];
  assign first_cell = (i == i0) && (j == j0);
  assign better = cur_sample > stored_max;
  assign is_last_cell = (i == cfg.wr - 4'd1) && (j == cfg.wc - 4'd1) && !emitted;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_ROW;
      ST_ROW: begin
        if (i >= cfg.wr || t_val < 0) state_next = ST_OUT;
        else if (div_done) state_next = ST_COL;
      end
      ST_COL: begin
        if (!row_ok || j >= cfg.wc || u_val < 0) state_next = ST_ROW;
        else if (div_done && div_rem == 4'd0) state_next = ST_READ;
      end
      ST_READ: state_next = ST_UPD;
      ST_UPD: state_next = ST_COL;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // output decode
  always_comb begin
    in_ready = (state == ST_IDLE);
    div_start = 1'b0;
    div_dividend = 16'(t_val);
    div_divisor = cfg.rs;
    case (state)
      ST_ROW: begin
        div_dividend = 16'(t_val);
        div_divisor = cfg.rs;
        div_start = !div_busy && !(i >= cfg.wr || t_val < 0);
      end
      ST_COL: begin
        div_dividend = 16'(u_val);
        div_divisor = cfg.cs;
        div_start = !div_busy && row_ok && !(j >= cfg.wc || u_val < 0);
      end
      default: ;
    endcase
  end

  // write decision for the cell being updated
  always_comb begin
    wr_en = 1'b0;
    wr_entry = {1'b0, j[2:0], 1'b0, i[2:0], cur_sample};
    if (state == ST_UPD && col_live && (first_cell || better)) wr_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) rd_entry <= store[addr];
    else if (wr_en) rd_entry <= wr_entry;
    if (wr_en) store[addr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row_counter <= '0;
      col_counter <= '0;
      chan_counter <= '0;
      out_valid <= 1'b0;
      div_busy <= 1'b0;
      emitted <= 1'b0;
      i <= '0;
      j <= '0;
      row_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (div_start) div_busy <= 1'b1;
      else if (div_done) div_busy <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid) begin
          cur_sample <= in_data.sample;
          cur_last <= in_data.frame_last;
          r <= row_counter;
          x <= ({1'b0, col_counter} >= cfg.width[8:0] && cfg.width != 10'd256)
               ? 9'd0 : {1'b0, col_counter};
          c <= ({1'b0, chan_counter} >= cfg.chans) ? '0 : chan_counter;
          i <= 4'd0;
          j <= 4'd0;
          row_ok <= 1'b0;
          emitted <= 1'b0;
        end
        ST_ROW: begin
          if (div_done) begin
            oh <= div_q;
            row_ok <= (div_rem == 4'd0);
            j <= 4'd0;
          end
        end
        ST_COL: begin
          if (row_ok) begin
            i0 <= ({17'd0, cfg.tp} > oh_rs) ? 4'(20'(cfg.tp) - oh_rs) : 4'd0;
          end
          if (!row_ok || j >= cfg.wc || u_val < 0) begin
            i <= i + 4'd1;
            row_ok <= 1'b0;
          end else if (div_done) begin
            ow <= div_q;
            if (div_rem != 4'd0) begin
              j <= j + 4'd1;
            end
          end
        end
        ST_READ: begin
          if (!col_live) begin
            // skip: treat as done without update
          end
        end
        ST_UPD: begin
          if (col_live && is_last_cell) begin
            emitted <= 1'b1;
            out_valid <= 1'b1;
            out_data.pooled_max <= (first_cell || better) ? cur_sample : stored_max;
            out_data.win_row_offset <= (first_cell || better) ? i[2:0] : rd_entry[18:16];
            out_data.win_col_offset <= (first_cell || better) ? j[2:0] : rd_entry[22:20];
            out_data.out_row <= oh[11:0];
            out_data.out_col <= ow[7:0];
            out_data.out_channel <= c;
            out_data.frame_done <= cur_last;
          end
          j <= j + 4'd1;
        end
        ST_OUT: if (out_free) begin
          if (cur_last) begin
            row_counter <= '0;
            col_counter <= '0;
            chan_counter <= '0;
          end else if ({1'b0, c} + 7'd1 >= cfg.chans) begin
            chan_counter <= '0;
            if ({1'b0, x} + 10'd1 >= cfg.width) begin
              col_counter <= '0;
              row_counter <= r + 12'd1;
            end else begin
              col_counter <= 8'(x + 9'd1);
            end
          end else begin
            chan_counter <= c + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_busy || div_done) else $error("divider busy at idle");
`endif

endmodule

FILE: rtl/mpa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_cfg_regs: configuration register file
// holds the eight pooling registers and presents clamped values
// ----------------------------------------------------------------------------
module mpa_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mpa_pkg::CFG_BITS-1:0]  cfg_data,
  output mpa_pkg::cfg_t                 cfg
);
  import mpa_pkg::*;

  logic [8:0] map_width;
  logic [6:0] channel_count;
  logic [3:0] window_rows, window_cols, row_step, col_step;
  logic [2:0] top_pad, left_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= 9'd8;
      channel_count <= 7'd1;
      window_rows <= 4'd2;
      window_cols <= 4'd2;
      row_step <= 4'd2;
      col_step <= 4'd2;
      top_pad <= 3'd0;
      left_pad <= 3'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAP_WIDTH:     map_width <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[6:0];
        REG_WINDOW_ROWS:   window_rows <= cfg_data[3:0];
        REG_WINDOW_COLS:   window_cols <= cfg_data[3:0];
        REG_ROW_STEP:      row_step <= cfg_data[3:0];
        REG_COL_STEP:      col_step <= cfg_data[3:0];
        REG_TOP_PAD:       top_pad <= cfg_data[2:0];
        REG_LEFT_PAD:      left_pad <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp to legal ranges
  always_comb begin
    cfg.width = (map_width == 9'd0) ? 10'd1 :
                (map_width > 9'd256) ? 10'd256 : {1'b0, map_width};
    cfg.chans = (channel_count == 7'd0) ? 7'd1 :
                (channel_count > 7'd64) ? 7'd64 : channel_count;
    cfg.wr = (window_rows == 4'd0) ? 4'd1 : (window_rows > 4'd8) ? 4'd8 : window_rows;
    cfg.wc = (window_cols == 4'd0) ? 4'd1 : (window_cols > 4'd8) ? 4'd8 : window_cols;
    cfg.rs = (row_step == 4'd0) ? 4'd1 : row_step;
    cfg.cs = (col_step == 4'd0) ? 4'd1 : col_step;
    cfg.tp = top_pad;
    cfg.lp = left_pad;
  end

endmodule

FILE: rtl/mpa_divstep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_divstep: shared restoring divider by a 4-bit step
// one quotient bit per cycle, used for row and column window indexes
// ----------------------------------------------------------------------------
module mpa_divstep (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [3:0]  divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [3:0]  remainder
);
  import mpa_pkg::*;

  logic [4:0]  count;
  logic [15:0] q;
  logic [4:0]  rem;
  logic        busy;
  logic [4:0]  trial;

  always_comb begin
    trial = {rem[3:0], q[15]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        q <= {q[14:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[14:0], 1'b0};
      end
    end
  end

  assign quotient = q;
  assign remainder = rem[3:0];

endmodule
